// ----- design/olif_pkg.sv -----
package olif_pkg;

  localparam int DataW   = 32;
  localparam int DepthDef = 16;
  localparam int CmdW    = 3;
  localparam int PosW    = 5;
  localparam int StatusW = 2;
  localparam int FoundW  = 4;
  localparam int TotalW  = 5;

  // command codes
  localparam logic [CmdW-1:0] CmdAppend  = 3'd0;
  localparam logic [CmdW-1:0] CmdPrepend = 3'd1;
  localparam logic [CmdW-1:0] CmdInsert  = 3'd2;
  localparam logic [CmdW-1:0] CmdFind    = 3'd3;
  localparam logic [CmdW-1:0] CmdReplace = 3'd4;
  localparam logic [CmdW-1:0] CmdRemove  = 3'd5;

  // status codes
  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StFull   = 2'd1;
  localparam logic [StatusW-1:0] StPos    = 2'd2;
  localparam logic [StatusW-1:0] StAbsent = 2'd3;

  typedef enum logic [1:0] {
    OP_KEEP,
    OP_INSERT,
    OP_REPLACE,
    OP_REMOVE
  } olif_op_t;

  // per-cell control: operation plus where the cell sits against the target
  typedef struct packed {
    olif_op_t op;
    logic     eq;
    logic     gt;
  } olif_cell_ctl_t;

endpackage

// ----- design/olif_cell.sv -----
module olif_cell (
  input  logic                        clk,
  input  olif_pkg::olif_cell_ctl_t    ctl_i,
  input  logic [olif_pkg::DataW-1:0]  value_i,
  input  logic [olif_pkg::DataW-1:0]  left_i,
  input  logic [olif_pkg::DataW-1:0]  right_i,
  input  logic [olif_pkg::DataW-1:0]  cmp_i,
  output logic [olif_pkg::DataW-1:0]  data_o,
  output logic                        match_o
);

  logic [olif_pkg::DataW-1:0] data_r;
  logic [olif_pkg::DataW-1:0] data_nxt;
  logic                       match_r;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl_i.op)
      olif_pkg::OP_KEEP: ;
      olif_pkg::OP_INSERT: begin
        if (ctl_i.eq) begin
          data_nxt = value_i;
        end else if (ctl_i.gt) begin
          data_nxt = left_i;
        end
      end
      olif_pkg::OP_REPLACE: begin
        if (ctl_i.eq) begin
          data_nxt = value_i;
        end
      end
      olif_pkg::OP_REMOVE: begin
        if (ctl_i.eq || ctl_i.gt) begin
          data_nxt = right_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= (data_r == cmp_i);
  end

  assign data_o  = data_r;
  assign match_o = match_r;

endmodule

// ----- design/olif_pick.sv -----
module olif_pick #(
  parameter int Depth = olif_pkg::DepthDef,
  localparam int IdxW = $clog2(Depth)
) (
  input  logic [Depth-1:0] match_i,
  output logic             hit_o,
  output logic [IdxW-1:0]  idx_o
);

  logic [Depth-1:0] lowest;

  // isolate lowest set bit, then encode it
  assign lowest = match_i & (~match_i + Depth'(1));
  assign hit_o  = |match_i;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < Depth; i++) begin
      idx_o = idx_o | (lowest[i] ? IdxW'(i) : '0);
    end
  end

endmodule

// ----- design/ordered_list_insert_remove_find_top.sv -----
// result: registered when the apply state completes; a new transaction
// is taken only once the last is applied; the accept cycle registers the per-cell
// compares, the apply state picks the first match and shifts the cell row
// a stalled result holds the row until the output transaction completes
// reset: synchronous active-low, clears the entry count and all handshake state;
// the entries themselves are not cleared and are never read before written
module ordered_list_insert_remove_find_top #(
  parameter int Depth = olif_pkg::DepthDef
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [olif_pkg::CmdW-1:0]             in_command,
  input  logic signed [olif_pkg::DataW-1:0]     in_value,
  input  logic [olif_pkg::PosW-1:0]             in_position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [olif_pkg::StatusW-1:0]          out_status,
  output logic [olif_pkg::FoundW-1:0]           out_found_index,
  output logic [olif_pkg::TotalW-1:0]           out_entry_total
);

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  // common width for comparing positions against the count
  localparam int CmpW = (CntW > olif_pkg::PosW) ? CntW : olif_pkg::PosW;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t                            state_r;
  logic [olif_pkg::CmdW-1:0]         cmd_r;
  logic [olif_pkg::DataW-1:0]        val_r;
  logic [olif_pkg::PosW-1:0]         pos_r;
  logic [CntW-1:0]                   count_r;
  logic [CntW-1:0]                   count_nxt;
  logic                              out_valid_r;
  logic [olif_pkg::StatusW-1:0]      status_r;
  logic [olif_pkg::StatusW-1:0]      status_nxt;
  logic [olif_pkg::FoundW-1:0]       found_r;
  logic [olif_pkg::FoundW-1:0]       found_nxt;
  logic [olif_pkg::TotalW-1:0]       total_r;

  logic                              apply_go;
  logic                              full;
  logic [CmpW-1:0]                   pos_x;
  logic [CmpW-1:0]                   cnt_x;
  logic [CmpW-1:0]                   target;
  olif_pkg::olif_op_t                op_sel;
  logic [olif_pkg::DataW-1:0]        cmp_val;

  logic [olif_pkg::DataW-1:0]        entries [Depth];
  logic [Depth-1:0]                  match_raw;
  logic [Depth-1:0]                  match_live;
  logic                              pick_hit;
  logic [IdxW-1:0]                   pick_idx;
  logic [IdxW+3:0]                   idx_wide;
  logic [CntW+3:0]                   cnt_wide;

  // one transaction in flight; the result register decouples the output side
  assign in_ready = (state_r == S_IDLE);
  assign apply_go = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  assign full  = (count_r == CntW'(Depth));
  assign pos_x = CmpW'(pos_r);
  assign cnt_x = CmpW'(count_r);

  // compare against the live input while idle, against the held value while
  // waiting to apply, so a stalled apply keeps its own compares
  assign cmp_val = in_ready ? in_value : val_r;

  // only entries below the count take part in a search
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      match_live[i] = match_raw[i] && (CntW'(i) < count_r);
    end
  end

  olif_pick #(
    .Depth (Depth)
  ) u_pick (
    .match_i (match_live),
    .hit_o   (pick_hit),
    .idx_o   (pick_idx)
  );

  assign idx_wide = (IdxW + 4)'(pick_idx);

  // command decode: status, found index, new count and the row operation
  always_comb begin
    op_sel     = olif_pkg::OP_KEEP;
    target     = '0;
    status_nxt = olif_pkg::StOk;
    found_nxt  = '0;
    count_nxt  = count_r;
    unique case (cmd_r)
      olif_pkg::CmdAppend: begin
        if (full) begin
          status_nxt = olif_pkg::StFull;
        end else begin
          op_sel    = olif_pkg::OP_INSERT;
          target    = cnt_x;
          count_nxt = count_r + CntW'(1);
        end
      end
      olif_pkg::CmdPrepend: begin
        if (full) begin
          status_nxt = olif_pkg::StFull;
        end else begin
          op_sel    = olif_pkg::OP_INSERT;
          count_nxt = count_r + CntW'(1);
        end
      end
      olif_pkg::CmdInsert: begin
        // position check takes priority over the full check
        if (pos_x > cnt_x) begin
          status_nxt = olif_pkg::StPos;
        end else if (full) begin
          status_nxt = olif_pkg::StFull;
        end else begin
          op_sel    = olif_pkg::OP_INSERT;
          target    = pos_x;
          count_nxt = count_r + CntW'(1);
        end
      end
      olif_pkg::CmdFind: begin
        if (pick_hit) begin
          found_nxt = idx_wide[olif_pkg::FoundW-1:0];
        end else begin
          status_nxt = olif_pkg::StAbsent;
        end
      end
      olif_pkg::CmdReplace: begin
        if (pos_x >= cnt_x) begin
          status_nxt = olif_pkg::StPos;
        end else begin
          op_sel = olif_pkg::OP_REPLACE;
          target = pos_x;
        end
      end
      olif_pkg::CmdRemove: begin
        if (pick_hit) begin
          op_sel    = olif_pkg::OP_REMOVE;
          target    = CmpW'(pick_idx);
          count_nxt = count_r - CntW'(1);
        end else begin
          status_nxt = olif_pkg::StAbsent;
        end
      end
      default: ;
    endcase
  end

  assign cnt_wide = (CntW + 4)'(count_nxt);

  // the cell row: each cell sees its left and right neighbour
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    olif_pkg::olif_cell_ctl_t   ctl;
    logic [olif_pkg::DataW-1:0] left_d;
    logic [olif_pkg::DataW-1:0] right_d;

    assign ctl.op = apply_go ? op_sel : olif_pkg::OP_KEEP;
    assign ctl.eq = (CmpW'(g) == target);
    assign ctl.gt = (CmpW'(g) > target);

    if (g == 0) begin : g_first
      // never shifted into from the left
      assign left_d = val_r;
    end else begin : g_mid_l
      assign left_d = entries[g-1];
    end

    if (g == Depth - 1) begin : g_last
      // last slot keeps its value on a remove, beyond the new count anyway
      assign right_d = entries[g];
    end else begin : g_mid_r
      assign right_d = entries[g+1];
    end

    // compares are ready at the accept edge and refreshed against the held value
    olif_cell u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .value_i (val_r),
      .left_i  (left_d),
      .right_i (right_d),
      .cmp_i   (cmp_val),
      .data_o  (entries[g]),
      .match_o (match_raw[g])
    );
  end

  // control state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces a departing one in the same cycle
      if (apply_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_command;
            val_r   <= in_value;
            pos_r   <= in_position;
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_go) begin
            count_r  <= count_nxt;
            status_r <= status_nxt;
            found_r  <= found_nxt;
            total_r  <= cnt_wide[olif_pkg::TotalW-1:0];
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_index = found_r;
  assign out_entry_total = total_r;

  // count never runs past the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("entry count beyond depth");

  // an accepted transaction moves straight to the apply cycle
  a_accept_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_APPLY))
    else $error("accepted transaction not applied");

  // a fresh result only appears out of the apply cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_APPLY))
    else $error("result without apply");

  // a full status means the row really is full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == olif_pkg::StFull)) |-> (count_r == CntW'(Depth)))
    else $error("full status with room left");

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import olif_pkg::*;

  localparam int ListDepth  = DepthDef;
  localparam int RandomCmds = 1450;
  localparam int CycleLimit = 200000;
  localparam int HoldAt     = 400;   // accepted commands before the long back-pressure
  localparam int LongHold   = 150;   // cycles the result side stays blocked
  localparam int QuietTail  = 8;     // cycles watched after the last result

  // command codes the block treats as no-ops
  localparam logic [CmdW-1:0] CmdSpare6 = 3'd6;
  localparam logic [CmdW-1:0] CmdSpare7 = 3'd7;

  typedef enum int {RdyAlways, RdyCoin, RdySparse, RdyPattern} ready_mode_t;
  typedef enum int {MixGrow, MixShrink, MixBalanced} cmd_mix_t;

  typedef struct {
    logic [CmdW-1:0]  command;
    logic [DataW-1:0] value;
    logic [PosW-1:0]  position;
    bit               pause_before;  // wait for every outstanding result first
  } list_cmd_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [FoundW-1:0]  found_index;
    logic [TotalW-1:0]  entry_total;
  } list_result_t;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    in_valid    = 1'b0;
  logic                    in_ready;
  logic [CmdW-1:0]         in_command  = '0;
  logic signed [DataW-1:0] in_value    = '0;
  logic [PosW-1:0]         in_position = '0;
  logic                    out_valid;
  logic                    out_ready   = 1'b0;
  logic [StatusW-1:0]      out_status;
  logic [FoundW-1:0]       out_found_index;
  logic [TotalW-1:0]       out_entry_total;

  // stimulus waiting to be offered, and results owed by the block
  list_cmd_t    pending_cmds[$];
  list_result_t owed_results[$];

  // mirror of the list contents and entry count
  logic [DataW-1:0] mirror_list [ListDepth];
  int               mirror_count = 0;

  int  errors        = 0;
  int  cycle_count   = 0;
  int  accepted_cmds = 0;
  logic in_taken     = 1'b0;   // input transaction completed at the last rising edge

  // sender pacing
  int        burst_left = 1;
  int        gap_left   = 0;
  list_cmd_t next_cmd;

  // receiver pacing
  ready_mode_t ready_mode  = RdyAlways;
  int          mode_left   = 40;
  int          ready_phase = 0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;

  // monitor scratch
  list_cmd_t    seen_cmd;
  list_result_t owed;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ordered_list_insert_remove_find_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_entry_total (out_entry_total)
  );

  // ---------------------------------------------------------------------------
  // list mirror
  // ---------------------------------------------------------------------------

  // index of the first live entry equal to val, or -1
  function automatic int first_match_at(input logic [DataW-1:0] val);
    int i;
    for (i = 0; i < mirror_count; i++)
      if (mirror_list[i] == val) return i;
    return -1;
  endfunction

  // shift entries at and above 'at' up by one and drop val in the hole
  function automatic void open_gap(input int at, input logic [DataW-1:0] val);
    int i;
    for (i = mirror_count; i > at; i--)
      mirror_list[i] = mirror_list[i-1];
    mirror_list[at] = val;
    mirror_count++;
  endfunction

  // apply one command to the mirror and return what the block must answer
  function automatic list_result_t apply_list_command(input list_cmd_t c);
    list_result_t r;
    int           hit;
    int           i;
    r.status      = StOk;
    r.found_index = '0;
    case (c.command)
      CmdAppend, CmdPrepend: begin
        if (mirror_count >= ListDepth) r.status = StFull;
        else open_gap((c.command == CmdAppend) ? mirror_count : 0, c.value);
      end
      CmdInsert: begin
        // range check wins over the full check
        if (int'(c.position) > mirror_count) r.status = StPos;
        else if (mirror_count >= ListDepth) r.status = StFull;
        else open_gap(int'(c.position), c.value);
      end
      CmdFind: begin
        hit = first_match_at(c.value);
        if (hit < 0) r.status = StAbsent;
        else r.found_index = FoundW'(hit);
      end
      CmdReplace: begin
        if (int'(c.position) >= mirror_count) r.status = StPos;
        else mirror_list[c.position] = c.value;
      end
      CmdRemove: begin
        hit = first_match_at(c.value);
        if (hit < 0) begin
          r.status = StAbsent;
        end else begin
          for (i = hit; i + 1 < mirror_count; i++)
            mirror_list[i] = mirror_list[i+1];
          mirror_count--;
        end
      end
      default: ;  // spare codes leave everything as it is
    endcase
    r.entry_total = TotalW'(mirror_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic void queue_command(input logic [CmdW-1:0] cmd,
                                        input logic [DataW-1:0] val,
                                        input logic [PosW-1:0] pos,
                                        input bit pause);
    list_cmd_t c;
    c.command      = cmd;
    c.value        = val;
    c.position     = pos;
    c.pause_before = pause;
    pending_cmds.push_back(c);
  endfunction

  function automatic void build_directed();
    int i;
    // empty list: every lookup and position check fails
    queue_command(CmdFind,    32'd5, 5'd0, 1'b0);
    queue_command(CmdRemove,  32'd5, 5'd0, 1'b0);
    queue_command(CmdReplace, 32'd5, 5'd0, 1'b0);
    queue_command(CmdInsert,  32'd5, 5'd1, 1'b0);
    // build [min, 5, 5, max, -1] with the extremes of the value range
    queue_command(CmdInsert,  32'd5,        5'd0, 1'b0);
    queue_command(CmdAppend,  32'h7fffffff, 5'd0, 1'b0);
    queue_command(CmdPrepend, 32'h80000000, 5'd0, 1'b0);
    queue_command(CmdInsert,  32'hffffffff, 5'd3, 1'b0);
    queue_command(CmdInsert,  32'd5,        5'd1, 1'b0);
    // duplicate values: first match is reported
    queue_command(CmdFind,    32'd5,        5'd0, 1'b0);
    queue_command(CmdFind,    32'hffffffff, 5'd0, 1'b0);
    queue_command(CmdReplace, 32'd0,        5'd4, 1'b0);
    queue_command(CmdReplace, 32'd0,        5'd5, 1'b0);
    queue_command(CmdRemove,  32'd5,        5'd0, 1'b0);
    queue_command(CmdRemove,  32'd1,        5'd0, 1'b0);
    // spare codes and an all-ones position
    queue_command(CmdSpare6,  32'hffffffff, 5'd31, 1'b0);
    queue_command(CmdSpare7,  32'd0,        5'd31, 1'b0);
    queue_command(CmdInsert,  32'd0,        5'd31, 1'b0);
    // fill to the brim, then hit the full list
    for (i = 0; i < 12; i++)
      queue_command(CmdAppend, 32'h1000 + i, 5'd0, 1'b0);
    queue_command(CmdAppend,  32'd7,        5'd0,  1'b0);
    queue_command(CmdPrepend, 32'd7,        5'd0,  1'b0);
    queue_command(CmdInsert,  32'd7,        5'd16, 1'b0);
    queue_command(CmdInsert,  32'd7,        5'd17, 1'b0);
    queue_command(CmdFind,    32'h100b,     5'd0,  1'b0);
    queue_command(CmdReplace, 32'h55aa55aa, 5'd15, 1'b0);
    queue_command(CmdRemove,  32'h80000000, 5'd0,  1'b0);
  endfunction

  // segments that lean towards growing, shrinking or a balance, so the count
  // keeps sweeping between empty and full; values mostly from a small set so
  // finds and removes land
  function automatic void build_random();
    int               made;
    int               seg;
    int               seg_len;
    int               k;
    int               roll;
    cmd_mix_t         mix;
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] val;
    logic [PosW-1:0]  pos;
    made = 0;
    seg  = 0;
    while (made < RandomCmds) begin
      seg_len = $urandom_range(30, 90);
      mix     = cmd_mix_t'(seg % 3);
      for (k = 0; k < seg_len; k++) begin
        roll = $urandom_range(0, 99);
        case (mix)
          MixGrow:
            cmd = (roll < 30) ? CmdAppend : (roll < 50) ? CmdPrepend :
                  (roll < 75) ? CmdInsert : (roll < 85) ? CmdFind :
                  (roll < 93) ? CmdReplace : (roll < 97) ? CmdRemove : CmdSpare6;
          MixShrink:
            cmd = (roll < 8)  ? CmdAppend : (roll < 12) ? CmdPrepend :
                  (roll < 20) ? CmdInsert : (roll < 35) ? CmdFind :
                  (roll < 45) ? CmdReplace : (roll < 97) ? CmdRemove : CmdSpare6;
          default:
            cmd = (roll < 15) ? CmdAppend : (roll < 25) ? CmdPrepend :
                  (roll < 45) ? CmdInsert : (roll < 65) ? CmdFind :
                  (roll < 80) ? CmdReplace : (roll < 97) ? CmdRemove : CmdSpare6;
        endcase
        if (cmd == CmdSpare6 && $urandom_range(0, 1) != 0) cmd = CmdSpare7;
        case ($urandom_range(0, 9))
          0: val = 32'h00000000;
          1: val = 32'hffffffff;
          2: val = 32'h80000000;
          3: val = 32'h7fffffff;
          4: val = 32'd1;
          5: val = 32'd42;
          6: val = 32'hdeadbeef;
          7: val = 32'h0000ff00;
          default: val = $urandom;
        endcase
        pos = ($urandom_range(0, 4) == 0) ? PosW'($urandom_range(0, 31))
                                          : PosW'($urandom_range(0, 17));
        // every fourth segment starts only once the block has drained
        queue_command(cmd, val, pos, (k == 0) && (seg % 4 == 3));
        made++;
      end
      seg++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers pending commands in bursts, changes inputs on falling edges
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // transaction still on offer, hold it
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() == 0 ||
                   (pending_cmds[0].pause_before && owed_results.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        next_cmd    = pending_cmds.pop_front();
        in_valid    <= 1'b1;
        in_command  <= next_cmd.command;
        in_value    <= next_cmd.value;
        in_position <= next_cmd.position;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          // a quarter of bursts run straight into the next one
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: own ready pattern, plus one long hold to back the block up
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_cmds >= HoldAt) begin
        out_ready <= 1'b0;
        hold_left <= LongHold;
        hold_done <= 1'b1;
      end else begin
        case (ready_mode)
          RdyAlways: out_ready <= 1'b1;
          RdyCoin:   out_ready <= ($urandom_range(0, 1) != 0);
          RdySparse: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ((ready_phase % 5) < 3);
        endcase
        ready_phase <= ready_phase + 1;
        if (mode_left == 0) begin
          ready_mode <= ready_mode_t'($urandom_range(0, 3));
          mode_left  <= $urandom_range(20, 120);
        end else begin
          mode_left <= mode_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks result transactions, then records accepted commands
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      // check before recording, so an early result never meets its own command
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("result transaction with nothing owed: status %0d, found_index %0d, entry_total %0d",
                 out_status, out_found_index, out_entry_total);
          errors++;
        end else begin
          owed = owed_results.pop_front();
          if (out_status !== owed.status) begin
            $error("status mismatch: expected %0d, actual %0d", owed.status, out_status);
            errors++;
          end
          if (out_found_index !== owed.found_index) begin
            $error("found_index mismatch: expected %0d, actual %0d",
                   owed.found_index, out_found_index);
            errors++;
          end
          if (out_entry_total !== owed.entry_total) begin
            $error("entry_total mismatch: expected %0d, actual %0d",
                   owed.entry_total, out_entry_total);
            errors++;
          end
        end
      end
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        seen_cmd.command      = in_command;
        seen_cmd.value        = in_value;
        seen_cmd.position     = in_position;
        seen_cmd.pause_before = 1'b0;
        owed_results.push_back(apply_list_command(seen_cmd));
        accepted_cmds <= accepted_cmds + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------
  initial begin
    build_directed();
    build_random();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // everything offered, taken and answered
    while (pending_cmds.size() != 0 || in_valid || owed_results.size() != 0)
      @(posedge clk);
    // a little longer to catch a stray result
    repeat (QuietTail) @(posedge clk);
    if (errors == 0 && owed_results.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
